[rtl/core/hls_pkg.sv]
package hls_pkg;

	localparam int VALUE_W  = 31;
	localparam int HASH_W   = 30;
	localparam int FILL_W   = 9;
	localparam int OP_W     = 2;
	localparam int STATUS_W = 2;

	// residue before final correction, always below 3p
	localparam int RED_W    = HASH_W + 2;
	localparam int PROD_W   = 2 * HASH_W;
	localparam int MU_W     = HASH_W + 1;
	localparam int ENT_W    = VALUE_W + HASH_W;

	localparam int STACK_DEPTH_DEF = 256;
	localparam int HASH_BASE       = 5;

	localparam logic [HASH_W-1:0] HASH_PRIME = 30'd1000000007;
	localparam logic [HASH_W-1:0] HASH_SEED  = 30'h0fdca;
	// floor(2^60 / p)
	localparam logic [MU_W-1:0]   BARRETT_MU = 31'd1152921496;

	localparam logic [RED_W-1:0] PRIME_R  = RED_W'(HASH_PRIME);
	localparam logic [RED_W-1:0] PRIME2_R = PRIME_R << 1;

	typedef enum logic [OP_W-1:0] {
		OP_PUSH = 2'd0,
		OP_POP  = 2'd1,
		OP_TOP  = 2'd2
	} op_t;

	typedef enum logic [STATUS_W-1:0] {
		ST_OK    = 2'd0,
		ST_UNDER = 2'd1,
		ST_OVER  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		UPD_NONE = 2'd0,
		UPD_ADD  = 2'd1,
		UPD_SUB  = 2'd2
	} upd_t;

	typedef struct packed {
		upd_t                upd;
		status_t             status;
		logic [VALUE_W-1:0]  value;
		logic [FILL_W-1:0]   fill;
	} side_t;

	typedef struct packed {
		side_t              side;
		logic [HASH_W-1:0]  a;
		logic [HASH_W-1:0]  b;
	} mul_req_t;

	// x < 3p -> x mod p
	function automatic logic [HASH_W-1:0] red3p(input logic [RED_W-1:0] x);
		if (x >= PRIME2_R) begin
			return HASH_W'(x - PRIME2_R);
		end else if (x >= PRIME_R) begin
			return HASH_W'(x - PRIME_R);
		end else begin
			return HASH_W'(x);
		end
	endfunction

endpackage

[rtl/core/hls_in_if.sv]
interface hls_in_if;
	import hls_pkg::*;

	logic               valid;
	logic               ready;
	logic [OP_W-1:0]    op;
	logic [VALUE_W-1:0] push_value;

	modport source (output valid, output op, output push_value, input ready);
	modport sink   (input valid, input op, input push_value, output ready);
endinterface

[rtl/core/hls_out_if.sv]
interface hls_out_if;
	import hls_pkg::*;

	logic                valid;
	logic                ready;
	logic [VALUE_W-1:0]  out_value;
	logic [STATUS_W-1:0] status;
	logic [FILL_W-1:0]   fill;
	logic [HASH_W-1:0]   content_hash;

	modport source (output valid, output out_value, output status, output fill,
		output content_hash, input ready);
	modport sink   (input valid, input out_value, input status, input fill,
		input content_hash, output ready);
endinterface

[rtl/core/hls_ram.sv]
module hls_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [WIDTH-1:0]         rd_data
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem[wr_addr] <= wr_data;
		end
		rd_data <= mem[rd_addr];
	end
endmodule

[rtl/core/hls_stack_ctrl.sv]
module hls_stack_ctrl #(
	parameter int STACK_DEPTH = hls_pkg::STACK_DEPTH_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	hls_in_if.sink            req,
	input  logic              pipe_ready,
	output logic              mul_vld,
	output hls_pkg::mul_req_t mul_req
);
	import hls_pkg::*;

	localparam int SP_W   = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W = $clog2(STACK_DEPTH);
	localparam int P5_W   = HASH_W + 3;

	logic [SP_W-1:0]    sp_q, sp_n;
	logic [VALUE_W-1:0] top_val_q, top_val_n, opnd;
	logic [HASH_W-1:0]  top_pow_q, top_pow_n;
	logic [HASH_W-1:0]  pow_q, pow_n, pow5, pow_sel;
	logic [P5_W-1:0]    prod5;
	logic               acc, is_full, is_empty, wr_ok;
	logic [ENT_W-1:0]   rd_data;
	logic [ADDR_W-1:0]  rd_addr;
	side_t              side;

	assign req.ready = pipe_ready;
	assign acc       = req.valid && pipe_ready;
	assign mul_vld   = req.valid;
	assign is_full   = (sp_q == SP_W'(STACK_DEPTH));
	assign is_empty  = (sp_q == '0);

	// 5^(sp+1) mod p from 5^sp
	always_comb begin
		prod5 = P5_W'(pow_q) * P5_W'(HASH_BASE);
		pow5  = HASH_W'(prod5);
		for (int k = 1; k < HASH_BASE; k++) begin
			if (prod5 >= P5_W'(k) * P5_W'(HASH_PRIME)) begin
				pow5 = HASH_W'(prod5 - P5_W'(k) * P5_W'(HASH_PRIME));
			end
		end
	end

	always_comb begin
		side.upd    = UPD_NONE;
		side.status = ST_OK;
		side.value  = '0;
		sp_n        = sp_q;
		top_val_n   = top_val_q;
		top_pow_n   = top_pow_q;
		pow_n       = pow_q;
		wr_ok       = 1'b0;
		opnd        = top_val_q;
		pow_sel     = top_pow_q;
		case (req.op)
			OP_PUSH: begin
				if (is_full) begin
					side.status = ST_OVER;
				end else begin
					side.upd  = UPD_ADD;
					opnd      = req.push_value;
					pow_sel   = pow_q;
					sp_n      = sp_q + SP_W'(1);
					top_val_n = req.push_value;
					top_pow_n = pow_q;
					pow_n     = pow5;
					wr_ok     = 1'b1;
				end
			end
			OP_POP: begin
				if (is_empty) begin
					side.status = ST_UNDER;
				end else begin
					side.upd   = UPD_SUB;
					side.value = top_val_q;
					sp_n       = sp_q - SP_W'(1);
					// entry below the top was prefetched last cycle
					top_val_n  = rd_data[ENT_W-1:HASH_W];
					top_pow_n  = rd_data[HASH_W-1:0];
					pow_n      = top_pow_q;
				end
			end
			OP_TOP: begin
				if (is_empty) begin
					side.status = ST_UNDER;
				end else begin
					side.value = top_val_q;
				end
			end
			default: begin
			end
		endcase
		side.fill = FILL_W'(sp_n);
	end

	assign mul_req.side = side;
	assign mul_req.a    = red3p(RED_W'(opnd));
	assign mul_req.b    = pow_sel;

	// always fetch the level just below the next top
	assign rd_addr = ADDR_W'((acc ? sp_n : sp_q) - SP_W'(2));

	hls_ram #(
		.WIDTH (ENT_W),
		.DEPTH (STACK_DEPTH)
	) u_store (
		.clk     (clk),
		.wr_en   (acc && wr_ok),
		.wr_addr (sp_q[ADDR_W-1:0]),
		.wr_data ({req.push_value, pow_q}),
		.rd_addr (rd_addr),
		.rd_data (rd_data)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			sp_q  <= '0;
			pow_q <= HASH_W'(1);
		end else if (acc) begin
			sp_q  <= sp_n;
			pow_q <= pow_n;
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			top_val_q <= top_val_n;
			top_pow_q <= top_pow_n;
		end
	end

	a_sp_range: assert property (@(posedge clk) disable iff (!arst_n)
		sp_q <= SP_W'(STACK_DEPTH))
		else $error("stack pointer beyond depth");

	a_pow_range: assert property (@(posedge clk) disable iff (!arst_n)
		pow_q < HASH_PRIME)
		else $error("level power not reduced");

	a_pop_dec: assert property (@(posedge clk) disable iff (!arst_n)
		(acc && req.op == OP_POP && !is_empty) |=> (sp_q == $past(sp_q) - SP_W'(1)))
		else $error("pop did not lower the stack pointer");
endmodule

[rtl/core/hls_term_pipe.sv]
module hls_term_pipe (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_vld,
	output logic                        in_rdy,
	input  hls_pkg::mul_req_t           in_req,
	output logic                        out_vld,
	input  logic                        out_rdy,
	output hls_pkg::side_t              out_side,
	output logic [hls_pkg::HASH_W-1:0]  out_term
);
	import hls_pkg::*;

	logic v_s1, v_s2, v_s3, v_s4, v_s5;
	logic ld1, ld2, ld3, ld4, ld5;

	mul_req_t            req_s1;
	side_t               side_s2, side_s3, side_s4, side_s5;
	logic [PROD_W-1:0]   x_s2;
	logic [HASH_W-1:0]   q_s3;
	logic [RED_W-1:0]    xlo_s3;
	logic [RED_W-1:0]    r_s4;
	logic [HASH_W-1:0]   term_s5;
	logic [2*MU_W-1:0]   prod_mu;
	logic [RED_W-1:0]    qp;

	// a stage loads when it is empty or its content moves on
	assign ld5    = !v_s5 || out_rdy;
	assign ld4    = !v_s4 || ld5;
	assign ld3    = !v_s3 || ld4;
	assign ld2    = !v_s2 || ld3;
	assign ld1    = !v_s1 || ld2;
	assign in_rdy = ld1;

	// Barrett quotient estimate, at most 2 below the true quotient
	assign prod_mu = (2*MU_W)'(x_s2[PROD_W-1:HASH_W-1]) * (2*MU_W)'(BARRETT_MU);
	assign qp      = RED_W'(q_s3) * PRIME_R;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			if (ld1) v_s1 <= in_vld;
			if (ld2) v_s2 <= v_s1;
			if (ld3) v_s3 <= v_s2;
			if (ld4) v_s4 <= v_s3;
			if (ld5) v_s5 <= v_s4;
		end
	end

	always_ff @(posedge clk) begin
		if (ld1) begin
			req_s1 <= in_req;
		end
		if (ld2) begin
			x_s2    <= PROD_W'(req_s1.a) * PROD_W'(req_s1.b);
			side_s2 <= req_s1.side;
		end
		if (ld3) begin
			q_s3    <= prod_mu[2*HASH_W:HASH_W+1];
			xlo_s3  <= x_s2[RED_W-1:0];
			side_s3 <= side_s2;
		end
		if (ld4) begin
			r_s4    <= xlo_s3 - qp;
			side_s4 <= side_s3;
		end
		if (ld5) begin
			term_s5 <= red3p(r_s4);
			side_s5 <= side_s4;
		end
	end

	assign out_vld  = v_s5;
	assign out_side = side_s5;
	assign out_term = term_s5;

	// only terms that touch the hash carry defined operands
	a_term_range: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s5 && side_s5.upd != UPD_NONE) |-> (term_s5 < HASH_PRIME))
		else $error("hash term not fully reduced");
endmodule

[rtl/core/hashed_lifo_stack_unit.sv]
// channel | dir | payload                                  | beat when
// req     | in  | op, push_value                           | req.valid && req.ready
// rsp     | out | out_value, status, fill, content_hash    | rsp.valid && rsp.ready
//
// One request beat per cycle sustained while rsp is not stalled; its
// response is registered behind the modular multiply pipeline (three
// multipliers) and the running-hash output register.
// Stack pointer, top entry and level power update at acceptance, so requests
// back to back see each other's effect with no wait.
// Reset clears pointer and valid bits and loads level power with 1 and the
// hash with its seed; the entry store and the cached top are not cleared.
// A stalled rsp lets up to 5 more requests drain into the pipeline.
module hashed_lifo_stack_unit #(
	parameter int STACK_DEPTH = hls_pkg::STACK_DEPTH_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	hls_in_if.sink     req,
	hls_out_if.source  rsp
);
	import hls_pkg::*;

	logic               mul_vld, pipe_rdy;
	mul_req_t           mul_req;
	logic               t_vld, t_rdy;
	side_t              t_side;
	logic [HASH_W-1:0]  t_term;

	logic [HASH_W:0]    sum, diff;
	logic [HASH_W-1:0]  hash_n;

	logic               out_vld_q;
	logic [HASH_W-1:0]  hash_q;
	logic [VALUE_W-1:0] value_q;
	status_t            status_q;
	logic [FILL_W-1:0]  fill_q;

	// front end: pointer, cached top, entry store, term operands
	hls_stack_ctrl #(
		.STACK_DEPTH (STACK_DEPTH)
	) u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.req        (req),
		.pipe_ready (pipe_rdy),
		.mul_vld    (mul_vld),
		.mul_req    (mul_req)
	);

	// value * 5^level mod p
	hls_term_pipe u_term (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_vld   (mul_vld),
		.in_rdy   (pipe_rdy),
		.in_req   (mul_req),
		.out_vld  (t_vld),
		.out_rdy  (t_rdy),
		.out_side (t_side),
		.out_term (t_term)
	);

	// terms arrive in request order, so the running hash is applied here
	assign t_rdy = !out_vld_q || rsp.ready;
	assign sum   = (HASH_W+1)'(hash_q) + (HASH_W+1)'(t_term);
	assign diff  = (HASH_W+1)'(hash_q) - (HASH_W+1)'(t_term);

	always_comb begin
		case (t_side.upd)
			UPD_ADD: begin
				hash_n = (sum >= (HASH_W+1)'(HASH_PRIME)) ?
					HASH_W'(sum - (HASH_W+1)'(HASH_PRIME)) : HASH_W'(sum);
			end
			UPD_SUB: begin
				// borrow means it went negative: add p back
				hash_n = diff[HASH_W] ? HASH_W'(diff + (HASH_W+1)'(HASH_PRIME)) :
					HASH_W'(diff);
			end
			default: begin
				hash_n = hash_q;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
			hash_q    <= HASH_SEED;
		end else if (t_rdy) begin
			out_vld_q <= t_vld;
			if (t_vld) begin
				hash_q <= hash_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (t_rdy && t_vld) begin
			value_q  <= t_side.value;
			status_q <= t_side.status;
			fill_q   <= t_side.fill;
		end
	end

	assign rsp.valid        = out_vld_q;
	assign rsp.out_value    = value_q;
	assign rsp.status       = status_q;
	assign rsp.fill         = fill_q;
	assign rsp.content_hash = hash_q;

	a_hash_range: assert property (@(posedge clk) disable iff (!arst_n)
		hash_q < HASH_PRIME)
		else $error("running hash not reduced");

	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp.valid && rsp.status != ST_OK) |-> (rsp.out_value == '0))
		else $error("error beat carries a value");
endmodule

[test/hashed_lifo_stack_unit_check.sv]
module hashed_lifo_stack_unit_check (
	input  logic clk,
	input  logic arst_n,
	hls_in_if    req,
	hls_out_if   rsp,
	output int   errors,
	output int   replies_due
);
	timeunit 1ns;
	timeprecision 1ps;

	import hls_pkg::*;

	localparam int              DEPTH     = STACK_DEPTH_DEF;
	localparam longint unsigned PRIME     = 64'd1000000007;

	typedef struct packed {
		logic [VALUE_W-1:0] value;
		status_t            status;
		logic [FILL_W-1:0]  fill;
		logic [HASH_W-1:0]  hash;
	} reply_t;

	// shadow of the stack and its signature
	logic [VALUE_W-1:0] level_val [DEPTH];
	int unsigned        level_cnt;
	longint unsigned    signature;
	longint unsigned    pow5 [DEPTH+1];
	reply_t             pending_replies [$];

	initial begin
		pow5[0] = 1;
		for (int i = 1; i <= DEPTH; i++) begin
			pow5[i] = (pow5[i-1] * HASH_BASE) % PRIME;
		end
	end

	function automatic reply_t apply_request(input logic [OP_W-1:0] op,
		input logic [VALUE_W-1:0] val);
		reply_t          r;
		int unsigned     lvl;
		longint unsigned term;
		r.value  = '0;
		r.status = ST_OK;
		case (op)
			OP_PUSH: begin
				if (level_cnt >= DEPTH) begin
					r.status = ST_OVER;
				end else begin
					term      = (longint'(val) * pow5[level_cnt]) % PRIME;
					signature = (signature + term) % PRIME;
					level_val[level_cnt] = val;
					level_cnt++;
				end
			end
			OP_POP, OP_TOP: begin
				if (level_cnt == 0) begin
					r.status = ST_UNDER;
				end else begin
					lvl     = level_cnt - 1;
					r.value = level_val[lvl];
					if (op == OP_POP) begin
						term      = (longint'(r.value) * pow5[lvl]) % PRIME;
						signature = (signature + PRIME - term) % PRIME;
						level_cnt = lvl;
					end
				end
			end
			default: ;  // unused code: no change
		endcase
		r.fill = FILL_W'(level_cnt);
		r.hash = HASH_W'(signature);
		return r;
	endfunction

	task automatic note_field(input string field, input longint unsigned want,
		input longint unsigned got);
		errors++;
		$display("%0t: %s mismatch, expected 0x%0h, actual 0x%0h",
			$time, field, want, got);
	endtask

	always @(posedge clk or negedge arst_n) begin
		reply_t want;
		if (!arst_n) begin
			level_cnt   = 0;
			signature   = HASH_SEED;
			errors      = 0;
			replies_due = 0;
			pending_replies.delete();
		end else begin
			if (req.valid && req.ready) begin
				pending_replies.push_back(apply_request(req.op, req.push_value));
			end
			if (rsp.valid && rsp.ready) begin
				if (pending_replies.size() == 0) begin
					errors++;
					$display("%0t: reply beat, expected none, actual 0x%0h/%0d/%0d/0x%0h",
						$time, rsp.out_value, rsp.status, rsp.fill, rsp.content_hash);
				end else begin
					want = pending_replies.pop_front();
					if (rsp.out_value !== want.value)
						note_field("out_value", want.value, rsp.out_value);
					if (rsp.status !== want.status)
						note_field("status", want.status, rsp.status);
					if (rsp.fill !== want.fill)
						note_field("fill", want.fill, rsp.fill);
					if (rsp.content_hash !== want.hash)
						note_field("content_hash", want.hash, rsp.content_hash);
				end
			end
			replies_due = pending_replies.size();
		end
	end

endmodule

[test/hashed_lifo_stack_unit_test.sv]
module hashed_lifo_stack_unit_test;
	timeunit 1ns;
	timeprecision 1ps;

	import hls_pkg::*;

	localparam int CLK_PERIOD     = 10;
	localparam int RESET_CYCLES   = 9;
	localparam int IDLE_PCT       = 28;
	localparam int DEPTH          = STACK_DEPTH_DEF;
	localparam int WATCHDOG_LIMIT = 2000;
	// idle time after the last expected reply before the result is read
	localparam int DRAIN_CYCLES   = 12;
	localparam int MIX_BLOCKS     = 14;
	localparam int BLOCK_LEN      = 100;

	localparam logic [VALUE_W-1:0] VALUE_MAX = '1;

	logic clk = 1'b0;
	logic arst_n;
	// when set, neither side idles
	logic steady = 1'b0;

	int errors;
	int replies_due;
	int stall_cycles = 0;
	// rough depth seen from the stimulus side, only to steer op mix
	int fill_level = 0;

	hls_in_if  req_ch ();
	hls_out_if rsp_ch ();

	hashed_lifo_stack_unit i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_ch),
		.rsp    (rsp_ch)
	);

	hashed_lifo_stack_unit_check i_check (
		.clk         (clk),
		.arst_n      (arst_n),
		.req         (req_ch),
		.rsp         (rsp_ch),
		.errors      (errors),
		.replies_due (replies_due)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// Reply side: ready toggles on the falling edge, held high while steady.
	always @(negedge clk) begin
		rsp_ch.ready <= steady || ($urandom_range(0, 99) >= IDLE_PCT);
	end

	// Watchdog: any beat on either channel restarts the count.
	always @(posedge clk) begin
		if (arst_n) begin
			if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
				stall_cycles <= 0;
			end else if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("RESULT: ERROR");
				$finish;
			end else begin
				stall_cycles <= stall_cycles + 1;
			end
		end
	end

	// Called and returns on a falling edge. Random gaps go in front of the
	// beat; valid stays high into the next call when there is no gap, so it
	// never drops and rises in the same step.
	task automatic send_request(input op_t op, input logic [VALUE_W-1:0] val);
		while (!steady && $urandom_range(0, 99) < IDLE_PCT) begin
			req_ch.valid <= 1'b0;
			@(negedge clk);
		end
		req_ch.valid      <= 1'b1;
		req_ch.op         <= op;
		req_ch.push_value <= val;
		@(posedge clk);
		while (!req_ch.ready) @(posedge clk);
		case (op)
			OP_PUSH: if (fill_level < DEPTH) fill_level++;
			OP_POP:  if (fill_level > 0) fill_level--;
			default: ;
		endcase
		@(negedge clk);
	endtask

	// Values lean on the corners: zero, all ones, tiny, then full random.
	function automatic logic [VALUE_W-1:0] pick_value();
		case ($urandom_range(0, 9))
			0:       return '0;
			1:       return VALUE_MAX;
			2:       return VALUE_W'($urandom_range(0, 15));
			default: return VALUE_W'($urandom());
		endcase
	endfunction

	// push_pct of the beats push; the rest split two pops to one top.
	function automatic op_t pick_op(input int push_pct);
		int roll;
		roll = $urandom_range(0, 99);
		if (roll < push_pct) return OP_PUSH;
		return ($urandom_range(0, 2) == 0) ? OP_TOP : OP_POP;
	endfunction

	initial begin
		int push_pct;
		req_ch.valid      = 1'b0;
		req_ch.op         = OP_PUSH;
		req_ch.push_value = '0;
		rsp_ch.ready      = 1'b0;
		arst_n            = 1'b0;
		repeat (RESET_CYCLES) @(negedge clk);
		arst_n <= 1'b1;

		// Directed: reads on an empty stack underflow, the value extremes
		// and alternating bit patterns go through push, top and pop.
		send_request(OP_POP, '0);
		send_request(OP_TOP, VALUE_MAX);
		send_request(OP_PUSH, '0);
		send_request(OP_TOP, '0);
		send_request(OP_PUSH, VALUE_MAX);
		send_request(OP_TOP, '0);
		send_request(OP_POP, '0);
		send_request(OP_POP, '0);
		send_request(OP_POP, '0);
		send_request(OP_PUSH, VALUE_MAX);
		send_request(OP_PUSH, 31'd1);
		send_request(OP_PUSH, 31'h2aaa_aaaa);
		send_request(OP_PUSH, 31'h5555_5555);
		send_request(OP_TOP, '0);
		send_request(OP_POP, VALUE_MAX);
		send_request(OP_POP, '0);
		send_request(OP_POP, '0);
		send_request(OP_POP, '0);
		send_request(OP_TOP, '0);

		// Fill to the top, then knock on the full stack: pushes (overflow while
		// it is full) mixed with top reads and pops.
		while (fill_level < DEPTH) send_request(pick_op(90), pick_value());
		repeat (8) send_request(pick_op(70), pick_value());

		// Drain back to empty, then six more requests, mostly reads past the bottom.
		while (fill_level > 0) send_request(pick_op(8), pick_value());
		repeat (6) send_request(pick_op(20), pick_value());

		// Mixed traffic: each block picks a bias so the depth wanders.
		// A few blocks run with no idling on either side.
		for (int blk = 0; blk < MIX_BLOCKS; blk++) begin
			steady   <= (blk >= 5 && blk < 8);
			push_pct = 30 + 20 * $urandom_range(0, 2);
			repeat (BLOCK_LEN) send_request(pick_op(push_pct), pick_value());
		end
		steady       <= 1'b0;
		req_ch.valid <= 1'b0;

		while (replies_due != 0) @(negedge clk);
		repeat (DRAIN_CYCLES) @(negedge clk);

		if (errors == 0) begin
			$display("RESULT: OK");
		end else begin
			$display("RESULT: ERROR");
		end
		$finish;
	end

endmodule
